>>> rtl/gbd_pkg.sv
// gbd_pkg: shared types and constants for the four-bin Goertzel detector.
// Used by gbd_ctrl, gbd_datapath, goertzel_bin_detector and gbd_checker.
// No dependencies.
package gbd_pkg;

    localparam int ACC_WIDTH_DEF    = 48;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int NUM_BINS  = 4;
    localparam int BIN_W     = 2;
    localparam int CNT_W     = $clog2(2 * NUM_BINS);
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Q1.15 fraction bits: 2*cos term uses one less shift
    localparam int FRAC_OUT = 15;
    localparam int FRAC_UPD = 14;

    typedef logic [BIN_W-1:0] t_bin;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic signed [COEF_W-1:0] t_coef;

    localparam t_bin LAST_BIN = BIN_W'(NUM_BINS - 1);
    localparam t_cnt LAST_UPD = CNT_W'(NUM_BINS - 1);
    localparam t_cnt LAST_OUT = CNT_W'(2 * NUM_BINS - 1);

    localparam t_coef COS_RESET = 16'sh7FFF;
    localparam t_coef SIN_RESET = 16'sh0000;

    // register map
    localparam t_cfg_idx REG_COS0 = 3'd0;
    localparam t_cfg_idx REG_SIN0 = 3'd1;
    localparam t_cfg_idx REG_COS1 = 3'd2;
    localparam t_cfg_idx REG_SIN1 = 3'd3;
    localparam t_cfg_idx REG_COS2 = 3'd4;
    localparam t_cfg_idx REG_SIN2 = 3'd5;
    localparam t_cfg_idx REG_COS3 = 3'd6;
    localparam t_cfg_idx REG_SIN3 = 3'd7;

    // datapath operations
    typedef enum logic [1:0] {
        OP_UPD,   // recurrence step: x + 2cos*s1 - s2
        OP_OUTA,  // output pass A: s1 products with cos
        OP_OUTB   // output pass B: s1 products with sin, combine, emit
    } t_op;

    typedef struct packed {
        logic load;    // latch the incoming sample word
        logic valid;   // issue op into the pipeline this cycle
        t_op  op;
        t_bin bin;
    } t_cmd;

    typedef struct packed {
        logic hold;        // pipeline frozen on a blocked result
        logic frame_done;  // last result of the frame leaves, states clear
    } t_stat;

endpackage

>>> rtl/goertzel_bin_detector.sv
// goertzel_bin_detector: top level of the four-bin complex Goertzel detector.
// Depends on gbd_pkg, gbd_ctrl and gbd_datapath.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   sample   | i_in_valid / o_in_stall  | i_sample_re, i_sample_im, i_last_sample
//   result   | o_out_valid / i_out_stall| o_bin_slot, o_out_re, o_out_im, o_last_of_run
//   config   | i_cfg_we (no wait)     | i_cfg_index, i_cfg_data (Q1.15 cos/sin)
//
// For each sample word the bins step in turn, one per cycle unless a held
// result stalls the pipeline, through a shared pair of multiply lanes (real and
// imaginary) in a 4-stage pipeline. After a word with i_last_sample set, the next
// word waits for the bins' update issues, two output passes per bin, pipeline drain.
// Reset (i_rst_n low, synchronous) sets cos to 32767, sin to 0, bin states to zero.
// A stalled result holds the pipeline once the next result reaches the finish stage.
module goertzel_bin_detector #(
    parameter int ACC_WIDTH    = gbd_pkg::ACC_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = gbd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  gbd_pkg::t_cfg_idx              i_cfg_index,
    input  logic [gbd_pkg::COEF_W-1:0]     i_cfg_data,
    // sample words
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_im,
    input  logic                           i_last_sample,
    // result words
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output gbd_pkg::t_bin                  o_bin_slot,
    output logic signed [ACC_WIDTH-1:0]    o_out_re,
    output logic signed [ACC_WIDTH-1:0]    o_out_im,
    output logic                           o_last_of_run
);
    import gbd_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: update issue per bin, then on the last sample two output passes per bin
    gbd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_sample (i_last_sample),
        .o_in_stall    (o_in_stall),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    // coefficients, bin states, multiply/round/combine/finish pipe, output word
    gbd_datapath #(
        .ACC_WIDTH    (ACC_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .i_sample_re   (i_sample_re),
        .i_sample_im   (i_sample_im),
        .i_out_stall   (i_out_stall),
        .o_stat        (w_stat),
        .o_out_valid   (o_out_valid),
        .o_bin_slot    (o_bin_slot),
        .o_out_re      (o_out_re),
        .o_out_im      (o_out_im),
        .o_last_of_run (o_last_of_run)
    );

endmodule

>>> rtl/gbd_ctrl.sv
// gbd_ctrl: sequencer for the Goertzel detector; issues one bin op per cycle unless held.
// Depends on gbd_pkg. Drives gbd_datapath through t_cmd, watches t_stat.
module gbd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_sample,
    output logic          o_in_stall,
    input  gbd_pkg::t_stat i_stat,
    output gbd_pkg::t_cmd  o_cmd
);
    import gbd_pkg::*;

    typedef enum logic [1:0] {
        S_WAIT,
        S_UPD,
        S_OUT,
        S_DRAIN
    } t_state;

    t_state r_state;
    t_cnt   r_cnt;
    logic   r_last;
    logic   w_accept;

    // take the next word while the last bin of the current one issues
    assign o_in_stall = !((r_state == S_WAIT) ||
                          (r_state == S_UPD && r_cnt == LAST_UPD && !r_last && !i_stat.hold));
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd.load  = w_accept;
        o_cmd.valid = (r_state == S_UPD || r_state == S_OUT) && !i_stat.hold;
        if (r_state == S_UPD) begin
            o_cmd.op  = OP_UPD;
            o_cmd.bin = r_cnt[BIN_W-1:0];
        end else begin
            o_cmd.op  = r_cnt[0] ? OP_OUTB : OP_OUTA;
            o_cmd.bin = r_cnt[CNT_W-1:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
            r_cnt   <= '0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_WAIT: begin
                    if (w_accept) begin
                        r_last  <= i_last_sample;
                        r_cnt   <= '0;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (!i_stat.hold) begin
                        if (r_cnt == LAST_UPD) begin
                            r_cnt <= '0;
                            if (r_last) begin
                                r_state <= S_OUT;
                            end else if (w_accept) begin
                                r_last <= i_last_sample;
                            end else begin
                                r_state <= S_WAIT;
                            end
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stat.hold) begin
                        if (r_cnt == LAST_OUT) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_DRAIN: begin
                    if (i_stat.frame_done) begin
                        r_state <= S_WAIT;
                    end
                end
            endcase
        end
    end

endmodule

>>> rtl/gbd_datapath.sv
// gbd_datapath: coefficient registers, bin states and the 4-stage
// multiply / round / combine / finish pipeline. Depends on gbd_pkg.
module gbd_datapath #(
    parameter int ACC_WIDTH    = gbd_pkg::ACC_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = gbd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  gbd_pkg::t_cfg_idx              i_cfg_index,
    input  logic [gbd_pkg::COEF_W-1:0]     i_cfg_data,
    input  gbd_pkg::t_cmd                  i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_im,
    input  logic                           i_out_stall,
    output gbd_pkg::t_stat                 o_stat,
    output logic                           o_out_valid,
    output gbd_pkg::t_bin                  o_bin_slot,
    output logic signed [ACC_WIDTH-1:0]    o_out_re,
    output logic signed [ACC_WIDTH-1:0]    o_out_im,
    output logic                           o_last_of_run
);
    import gbd_pkg::*;

    localparam int PW = ACC_WIDTH + COEF_W;
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic [PW-1:0] HALF_OUT = PW'(1) << (FRAC_OUT - 1);
    localparam logic [PW-1:0] HALF_UPD = PW'(1) << (FRAC_UPD - 1);

    typedef logic signed [ACC_WIDTH-1:0] t_acc;
    typedef logic signed [PW-1:0]        t_prod;
    typedef logic signed [SAMPLE_WIDTH-1:0] t_smp;

    function automatic t_acc f_sat_add(input t_acc a, input t_acc b, input logic sub);
        logic signed [ACC_WIDTH:0] s;
        s = sub ? ((ACC_WIDTH+1)'(a) - (ACC_WIDTH+1)'(b))
                : ((ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(b));
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
            return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end
        return $signed(s[ACC_WIDTH-1:0]);
    endfunction

    // round half away from zero, then clamp to the accumulator range
    function automatic t_acc f_round(input t_prod p, input logic sh_out);
        t_prod r;
        t_prod s;
        r = p + (sh_out ? HALF_OUT : HALF_UPD) - {{(PW-1){1'b0}}, p[PW-1]};
        s = sh_out ? (r >>> FRAC_OUT) : (r >>> FRAC_UPD);
        if ((&s[PW-1:ACC_WIDTH-1]) || !(|s[PW-1:ACC_WIDTH-1])) begin
            return $signed(s[ACC_WIDTH-1:0]);
        end
        return s[PW-1] ? ACC_MIN : ACC_MAX;
    endfunction

    // configuration and bin state
    t_coef r_cos [NUM_BINS];
    t_coef r_sin [NUM_BINS];
    t_acc  r_prev_re  [NUM_BINS];
    t_acc  r_prev2_re [NUM_BINS];
    t_acc  r_prev_im  [NUM_BINS];
    t_acc  r_prev2_im [NUM_BINS];

    t_smp r_x_re;
    t_smp r_x_im;

    // multiply stage
    logic  r_m_vld;
    t_op   r_m_op;
    t_bin  r_m_bin;
    t_prod r_m_p0, r_m_p1;
    t_acc  r_m_a0, r_m_a1;
    t_smp  r_m_x_re, r_m_x_im;
    // round stage
    logic  r_r_vld;
    t_op   r_r_op;
    t_bin  r_r_bin;
    t_acc  r_r_q0, r_r_q1;
    t_acc  r_r_a0, r_r_a1;
    t_smp  r_r_x_re, r_r_x_im;
    // pass A hold
    t_acc  r_h0, r_h1;
    // finish stage
    logic  r_f_vld;
    t_op   r_f_op;
    t_bin  r_f_bin;
    t_acc  r_f_t0, r_f_t1;
    t_acc  r_f_a0, r_f_a1;
    // output word
    logic  r_o_valid;
    t_bin  r_o_bin;
    t_acc  r_o_re, r_o_im;
    logic  r_o_last;

    logic  w_en;
    logic  w_fire;
    t_acc  w_a0, w_a1;
    t_coef w_c;
    t_prod w_p0, w_p1;
    t_acc  n_q0, n_q1;
    t_acc  n_t0, n_t1;
    t_acc  n_y0, n_y1;

    // a result blocked in the finish stage freezes the whole pipe
    assign w_en   = !(r_f_vld && r_f_op == OP_OUTB && r_o_valid && i_out_stall);
    assign w_fire = r_f_vld && w_en;

    assign o_stat.hold       = !w_en;
    assign o_stat.frame_done = w_fire && r_f_op == OP_OUTB && r_f_bin == LAST_BIN;

    // issue: pass B swaps the lanes and uses the sine
    always_comb begin
        w_a0 = (i_cmd.op == OP_OUTB) ? r_prev_im[i_cmd.bin] : r_prev_re[i_cmd.bin];
        w_a1 = (i_cmd.op == OP_OUTB) ? r_prev_re[i_cmd.bin] : r_prev_im[i_cmd.bin];
        w_c  = (i_cmd.op == OP_OUTB) ? r_sin[i_cmd.bin] : r_cos[i_cmd.bin];
        w_p0 = PW'(w_a0) * PW'(w_c);
        w_p1 = PW'(w_a1) * PW'(w_c);
    end

    always_comb begin
        n_q0 = f_round(r_m_p0, r_m_op != OP_UPD);
        n_q1 = f_round(r_m_p1, r_m_op != OP_UPD);
    end

    always_comb begin
        if (r_r_op == OP_UPD) begin
            n_t0 = f_sat_add(ACC_WIDTH'(r_r_x_re), r_r_q0, 1'b0);
            n_t1 = f_sat_add(ACC_WIDTH'(r_r_x_im), r_r_q1, 1'b0);
        end else begin
            n_t0 = f_sat_add(r_h0, r_r_q0, 1'b1);
            n_t1 = f_sat_add(r_h1, r_r_q1, 1'b0);
        end
    end

    always_comb begin
        n_y0 = f_sat_add(r_f_t0, r_prev2_re[r_f_bin], 1'b1);
        n_y1 = f_sat_add(r_f_t1, r_prev2_im[r_f_bin], 1'b1);
    end

    // control: valids, coefficients, bin states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld   <= 1'b0;
            r_r_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_o_valid <= 1'b0;
            for (int b = 0; b < NUM_BINS; b++) begin
                r_cos[b]      <= COS_RESET;
                r_sin[b]      <= SIN_RESET;
                r_prev_re[b]  <= '0;
                r_prev2_re[b] <= '0;
                r_prev_im[b]  <= '0;
                r_prev2_im[b] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_COS0: r_cos[0] <= i_cfg_data;
                    REG_SIN0: r_sin[0] <= i_cfg_data;
                    REG_COS1: r_cos[1] <= i_cfg_data;
                    REG_SIN1: r_sin[1] <= i_cfg_data;
                    REG_COS2: r_cos[2] <= i_cfg_data;
                    REG_SIN2: r_sin[2] <= i_cfg_data;
                    REG_COS3: r_cos[3] <= i_cfg_data;
                    REG_SIN3: r_sin[3] <= i_cfg_data;
                endcase
            end
            if (w_en) begin
                r_m_vld <= i_cmd.valid;
                r_r_vld <= r_m_vld;
                r_f_vld <= r_r_vld && r_r_op != OP_OUTA;
            end
            if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            if (w_fire && r_f_op == OP_UPD) begin
                r_prev2_re[r_f_bin] <= r_f_a0;
                r_prev_re[r_f_bin]  <= n_y0;
                r_prev2_im[r_f_bin] <= r_f_a1;
                r_prev_im[r_f_bin]  <= n_y1;
            end
            if (w_fire && r_f_op == OP_OUTB) begin
                r_o_valid <= 1'b1;
                if (r_f_bin == LAST_BIN) begin
                    for (int b = 0; b < NUM_BINS; b++) begin
                        r_prev_re[b]  <= '0;
                        r_prev2_re[b] <= '0;
                        r_prev_im[b]  <= '0;
                        r_prev2_im[b] <= '0;
                    end
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x_re <= i_sample_re;
            r_x_im <= i_sample_im;
        end
        if (w_en) begin
            r_m_op   <= i_cmd.op;
            r_m_bin  <= i_cmd.bin;
            r_m_p0   <= w_p0;
            r_m_p1   <= w_p1;
            r_m_a0   <= w_a0;
            r_m_a1   <= w_a1;
            r_m_x_re <= r_x_re;
            r_m_x_im <= r_x_im;

            r_r_op   <= r_m_op;
            r_r_bin  <= r_m_bin;
            r_r_q0   <= n_q0;
            r_r_q1   <= n_q1;
            r_r_a0   <= r_m_a0;
            r_r_a1   <= r_m_a1;
            r_r_x_re <= r_m_x_re;
            r_r_x_im <= r_m_x_im;

            if (r_r_vld && r_r_op == OP_OUTA) begin
                r_h0 <= r_r_q0;
                r_h1 <= r_r_q1;
            end

            r_f_op  <= r_r_op;
            r_f_bin <= r_r_bin;
            r_f_t0  <= n_t0;
            r_f_t1  <= n_t1;
            r_f_a0  <= r_r_a0;
            r_f_a1  <= r_r_a1;
        end
        if (w_fire && r_f_op == OP_OUTB) begin
            r_o_bin  <= r_f_bin;
            r_o_re   <= n_y0;
            r_o_im   <= n_y1;
            r_o_last <= (r_f_bin == LAST_BIN);
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_bin_slot    = r_o_bin;
    assign o_out_re      = r_o_re;
    assign o_out_im      = r_o_im;
    assign o_last_of_run = r_o_last;

endmodule

>>> rtl/gbd_checker.sv
// gbd_port_checks: port-level assertions for goertzel_bin_detector, plus bind.
// Depends on gbd_pkg and goertzel_bin_detector.
module gbd_port_checks #(
    parameter int ACC_WIDTH = gbd_pkg::ACC_WIDTH_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input gbd_pkg::t_bin               o_bin_slot,
    input logic signed [ACC_WIDTH-1:0] o_out_re,
    input logic                        o_last_of_run
);
    import gbd_pkg::*;

    // blocked result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_re) && $stable(o_bin_slot))
        else $error("result word changed while stalled");

    // frame marker only on the highest bin
    a_last_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_run |-> o_bin_slot == LAST_BIN)
        else $error("last_of_run on wrong bin");

    // bins leave in increasing order
    a_bin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_run ##1 o_out_valid
        |-> o_bin_slot == BIN_W'($past(o_bin_slot) + 1'b1))
        else $error("bin results out of order");

    // no new sample while a frame still has results to give
    a_no_accept_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> o_in_stall)
        else $error("sample taken during result output");

endmodule

bind goertzel_bin_detector gbd_port_checks #(
    .ACC_WIDTH (ACC_WIDTH)
) u_gbd_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_bin_slot    (o_bin_slot),
    .o_out_re      (o_out_re),
    .o_last_of_run (o_last_of_run)
);
